// ===== rtl/fxd_txt_pkg.sv =====
// Shared types, constants and the helper function of the Q16.16 to decimal text formatter.
package fxd_txt_pkg;

	localparam int FractionDigits = 6;
	localparam int IntDigitsMax   = 5;
	localparam int DigitSlots     = FractionDigits;
	localparam int IntW           = 16;
	localparam int FracBits       = 16;
	localparam int SumW           = 27;
	localparam int FracW          = 20;
	localparam int CountW         = 4;

	localparam logic [SumW-1:0] StartWeight = SumW'(100000000);

	// floor(x / 100) = (x * RecipHundred) >> RecipHundredShift for x below 2^30.
	localparam logic [SumW-1:0] RecipHundred      = SumW'(85899346);
	localparam int              RecipHundredShift = 33;

	// floor(x / 10) by reciprocal multiplication, exact over the widths used.
	localparam logic [IntW-1:0]  RecipTenInt        = IntW'(52429);
	localparam int               RecipTenIntShift   = 19;
	localparam logic [FracW-1:0] RecipTenFrac       = FracW'(838861);
	localparam int               RecipTenFracShift  = 23;

	localparam logic [7:0] CharMinus = 8'h2D;
	localparam logic [7:0] CharPoint = 8'h2E;
	localparam logic [7:0] CharZero  = 8'h30;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic                       neg;
		logic [2:0]                 ndig;
		logic [IntW-1:0]            iw;
		logic [FracW-1:0]           fw;
		digit_t [DigitSlots-1:0]    idig;
		digit_t [DigitSlots-1:0]    fdig;
	} fxd_txt_work_t;

	// Weight of fraction bit b: the start weight halved (truncating) 16 - b times.
	function automatic logic [SumW-1:0] frac_weight(input int b);
		frac_weight = StartWeight >> (FracBits - b);
	endfunction

endpackage

// ===== rtl/fxd_txt_front.sv =====
// Front pipeline: sign and magnitude, fraction weight sum, divide by 100.
module fxd_txt_front import fxd_txt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [31:0]          value,
	output logic                 out_valid,
	output fxd_txt_work_t        out_work
);

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic                 neg_s1, neg_s2, neg_s3, neg_s4;
	logic [31:0]          mag_s1;
	logic [IntW-1:0]      ipart_s2, ipart_s3, ipart_s4;
	logic [2:0]           ndig_s2, ndig_s3, ndig_s4;
	logic [SumW-1:0]      sum_hi_s2, sum_lo_s2;
	logic [SumW-1:0]      frac_s3;
	logic [FracW-1:0]     frac6_s4;

	logic [SumW-1:0]      sum_hi, sum_lo;
	logic [2:0]           ndig;
	logic [IntW-1:0]      ipart;
	logic [2*SumW-1:0]    prod;

	assign ipart = mag_s1[31:16];

	always_comb begin
		sum_hi = '0;
		sum_lo = '0;
		for (int b = 0; b < FracBits / 2; b++) begin
			if (mag_s1[b])
				sum_lo = sum_lo + frac_weight(b);
			if (mag_s1[b + FracBits / 2])
				sum_hi = sum_hi + frac_weight(b + FracBits / 2);
		end
	end

	always_comb begin
		if (ipart >= IntW'(10000))
			ndig = 3'd5;
		else if (ipart >= IntW'(1000))
			ndig = 3'd4;
		else if (ipart >= IntW'(100))
			ndig = 3'd3;
		else if (ipart >= IntW'(10))
			ndig = 3'd2;
		else
			ndig = 3'd1;
	end

	assign prod = (2*SumW)'(frac_s3) * (2*SumW)'(RecipHundred);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1    <= value[31];
			mag_s1    <= value[31] ? (32'd0 - value) : value;

			neg_s2    <= neg_s1;
			ipart_s2  <= ipart;
			ndig_s2   <= ndig;
			sum_hi_s2 <= sum_hi;
			sum_lo_s2 <= sum_lo;

			neg_s3    <= neg_s2;
			ipart_s3  <= ipart_s2;
			ndig_s3   <= ndig_s2;
			frac_s3   <= sum_hi_s2 + sum_lo_s2;

			neg_s4    <= neg_s3;
			ipart_s4  <= ipart_s3;
			ndig_s4   <= ndig_s3;
			frac6_s4  <= FracW'(prod >> RecipHundredShift);
		end
	end

	assign out_valid     = vld_s4;
	assign out_work.neg  = neg_s4;
	assign out_work.ndig = ndig_s4;
	assign out_work.iw   = ipart_s4;
	assign out_work.fw   = frac6_s4;
	assign out_work.idig = '0;
	assign out_work.fdig = '0;

endmodule

// ===== rtl/fxd_txt_digit_step.sv =====
// One pipeline stage that peels the lowest decimal digit off the integer and fraction parts.
module fxd_txt_digit_step import fxd_txt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  fxd_txt_work_t   in_work,
	output logic            out_valid,
	output fxd_txt_work_t   out_work
);

	logic                    vld_s1;
	fxd_txt_work_t           work_s1;

	logic [2*IntW-1:0]       iprod;
	logic [2*FracW-1:0]      fprod;
	logic [IntW-1:0]         iq, irem;
	logic [FracW-1:0]        fq, frem;
	fxd_txt_work_t           nxt;

	assign iprod = (2*IntW)'(in_work.iw) * (2*IntW)'(RecipTenInt);
	assign fprod = (2*FracW)'(in_work.fw) * (2*FracW)'(RecipTenFrac);
	assign iq    = IntW'(iprod >> RecipTenIntShift);
	assign fq    = FracW'(fprod >> RecipTenFracShift);
	assign irem  = in_work.iw - ((iq << 3) + (iq << 1));
	assign frem  = in_work.fw - ((fq << 3) + (fq << 1));

	// New digits enter at the bottom, so after all steps slot 0 holds the most significant one.
	always_comb begin
		nxt      = in_work;
		nxt.iw   = iq;
		nxt.fw   = fq;
		nxt.idig = {in_work.idig[DigitSlots-2:0], irem[3:0]};
		nxt.fdig = {in_work.fdig[DigitSlots-2:0], frem[3:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			work_s1 <= nxt;
	end

	assign out_valid = vld_s1;
	assign out_work  = work_s1;

endmodule

// ===== rtl/fxd_txt_serial.sv =====
// Character serializer with holding register and registered output word.
module fxd_txt_serial import fxd_txt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  fxd_txt_work_t   in_work,
	output logic            take,
	output logic            out_valid,
	output logic [7:0]      out_char,
	output logic            out_last,
	input  logic            out_ready
);

	logic                    hold_v_q;
	fxd_txt_work_t           hold_q;
	logic [CountW-1:0]       pos_q;
	logic                    out_valid_q;
	logic [7:0]              out_char_q;
	logic                    out_last_q;

	logic                    out_ok, emit, is_last, fin;
	logic [CountW-1:0]       total, posx, ndig_w, iidx, fidx;
	logic [7:0]              ch;

	assign ndig_w  = CountW'(hold_q.ndig);
	assign total   = CountW'(hold_q.neg) + ndig_w + CountW'(FractionDigits + 1);
	assign posx    = pos_q - CountW'(hold_q.neg);
	assign iidx    = CountW'(DigitSlots) - ndig_w + posx;
	assign fidx    = posx - ndig_w - CountW'(1);
	assign is_last = (pos_q == total - CountW'(1));

	always_comb begin
		if (hold_q.neg && pos_q == '0)
			ch = CharMinus;
		else if (posx < ndig_w)
			ch = CharZero + 8'(hold_q.idig[iidx[2:0]]);
		else if (posx == ndig_w)
			ch = CharPoint;
		else
			ch = CharZero + 8'(hold_q.fdig[fidx[2:0]]);
	end

	assign out_ok = !out_valid_q || out_ready;
	assign emit   = hold_v_q && out_ok;
	assign fin    = emit && is_last;
	assign take   = !hold_v_q || fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q    <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				hold_v_q <= in_valid;
				pos_q    <= '0;
			end else if (emit) begin
				pos_q <= pos_q + CountW'(1);
			end
			if (out_ok)
				out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			hold_q <= in_work;
		if (emit) begin
			out_char_q <= ch;
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> pos_q < total)
		else $error("character position ran past the end of the number");

	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		emit && ch == CharMinus |-> pos_q == '0)
		else $error("minus sign emitted away from the first character");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> pos_q == '0)
		else $error("new number did not start at its first character");

	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> out_valid_q && out_last_q)
		else $error("final character was not marked last");

endmodule

// ===== rtl/fixed16_16_to_decimal_text_unit.sv =====
// Top level of the Q16.16 to decimal text formatter.
//
// Each input word is a signed Q16.16 number (two's complement). For each one the block sends
// its decimal text as ASCII characters, one character per output word: a minus sign if the
// number is negative, the integer part without leading zeros (a single '0' if it is zero),
// a point, and six fraction digits with leading zeros; tlast marks the final character. The
// fraction is the sum of truncated binary weights starting from 1e8, divided by 100, so the
// digits are truncated, not rounded. A number takes from 8 to 13 output words
// (sign + integer digits + 7), and the output port moves one character per cycle while
// m_tready is high, so the character serializer sets the sustained rate of numbers.
// Inputs are taken every cycle until the ten-stage front pipeline (negate, weight sum,
// divide by 100, six digit-extraction stages) backs up behind the serializer. With an idle
// output, an accepted word passes the ten pipeline registers, the serializer's holding
// register and the output register before its first character is valid.
module fixed16_16_to_decimal_text_unit import fxd_txt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] value
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // [7:0] char_code
	output logic         m_tlast
);

	logic            en;
	logic            vld [0:DigitSlots];
	fxd_txt_work_t   work [0:DigitSlots];

	// The whole pipeline advances when the serializer can take its last stage.
	assign s_tready = en;

	fxd_txt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.value     (s_tdata),
		.out_valid (vld[0]),
		.out_work  (work[0])
	);

	// One decimal digit of each part is produced per stage.
	for (genvar g = 0; g < DigitSlots; g++) begin : g_digit
		fxd_txt_digit_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld[g]),
			.in_work   (work[g]),
			.out_valid (vld[g+1]),
			.out_work  (work[g+1])
		);
	end

	fxd_txt_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[DigitSlots]),
		.in_work   (work[DigitSlots]),
		.take      (en),
		.out_valid (m_tvalid),
		.out_char  (m_tdata),
		.out_last  (m_tlast),
		.out_ready (m_tready)
	);

endmodule

// ===== dv/fixed16_16_to_decimal_text_unit_tb.sv =====
// Self-checking testbench for the Q16.16 to decimal text formatter.
`timescale 1ns / 100ps

module fixed16_16_to_decimal_text_unit_tb;

	// A quiet spell this long means the block has hung. The slowest correct case is a
	// long receiver stall or the fill of the front pipeline, so this leaves a wide margin.
	localparam int QuietLimit = 2000;
	// Cycles allowed after the last character before the verdict, to catch extra words.
	localparam int TailCycles = 40;

	// One expected character of the text, in the order the block must send it.
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;    // [31:0] value
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [7:0] char_code
	logic        m_tlast;

	// Characters still owed by the block, oldest first.
	text_char_t expected_text[$];

	int error_count   = 0;
	int quiet_cycles  = 0;
	// Percent of cycles in which the sender holds back or the receiver stalls.
	int send_idle_pct = 0;
	int stall_pct     = 0;

	fixed16_16_to_decimal_text_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what);
		$display("%0t ns: MISMATCH %s", $time, what);
		error_count++;
	endtask

	// Works out the text of one Q16.16 number and appends it to the expected characters.
	// The magnitude is taken as an unsigned 32-bit value, so the most negative number
	// comes out as 32768 with a minus sign. The fraction is the sum of the truncated
	// halvings of 1e8 for each set fraction bit, cut down to six digits by a divide by 100.
	function automatic void push_decimal_text(input logic [31:0] value);
		logic        negative;
		logic [31:0] magnitude;
		logic [31:0] int_part;
		logic [31:0] weight;
		logic [31:0] frac_sum;
		logic [3:0]  int_digits[5];
		logic [3:0]  frac_digits[6];
		int          n_int;
		text_char_t  c;
		negative  = value[31];
		magnitude = negative ? (32'd0 - value) : value;
		int_part  = {16'd0, magnitude[31:16]};
		weight    = 32'd100000000;
		frac_sum  = '0;
		for (int b = 15; b >= 0; b--) begin
			weight = weight >> 1;
			if (magnitude[b]) begin
				frac_sum = frac_sum + weight;
			end
		end
		frac_sum = frac_sum / 100;
		// Integer digits, least significant first; zero still gives one digit.
		n_int = 0;
		do begin
			int_digits[n_int] = 4'(int_part % 10);
			int_part = int_part / 10;
			n_int++;
		end while (int_part != 0 && n_int < 5);
		for (int k = 5; k >= 0; k--) begin
			frac_digits[k] = 4'(frac_sum % 10);
			frac_sum = frac_sum / 10;
		end
		c.last = 1'b0;
		if (negative) begin
			c.code = 8'h2D;
			expected_text.push_back(c);
		end
		for (int k = n_int - 1; k >= 0; k--) begin
			c.code = 8'h30 + 8'(int_digits[k]);
			expected_text.push_back(c);
		end
		c.code = 8'h2E;
		expected_text.push_back(c);
		for (int k = 0; k < 6; k++) begin
			c.code = 8'h30 + 8'(frac_digits[k]);
			c.last = (k == 5);
			expected_text.push_back(c);
		end
	endfunction

	// Receiver: ready is redrawn every cycle, so stalls land on every character position.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Both handshakes are sampled at the rising edge. An accepted input word queues its
	// text; an accepted output word is checked against the oldest queued character.
	// Any cycle with neither handshake advances the hang counter.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_text.size() == 0) begin
					report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
						m_tdata, m_tlast));
				end else begin
					want = expected_text.pop_front();
					if (m_tdata !== want.code) begin
						report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
							m_tdata, want.code));
					end
					if (m_tlast !== want.last) begin
						report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
							m_tlast, want.last, want.code));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				push_decimal_text(s_tdata);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Offers one number and returns right after the edge that accepts it. Valid is left
	// high so the next word can follow back to back; only an idle cycle lowers it.
	// Ready is looked at on the falling edge, where it is settled for the coming edge.
	task automatic send_value(input logic [31:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(negedge clk);
		while (!s_tready) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	// Lowers valid and holds off until every owed character has been received.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_text.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Field extremes and the special cases: the most negative number, a zero integer
	// part, a negative value below one, the widest integer, the lowest and highest fraction
	// bits alone, and integer lengths from one to five digits.
	task automatic test_directed();
		logic [31:0] values[$];
		values = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h0000_0001, 32'hFFFF_8000, 32'h0000_8000, 32'h0000_FFFF,
			32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_0000, 32'h8000_0001,
			32'h0009_0000, 32'h000A_0000, 32'h0063_FFFF, 32'h0064_0000,
			32'h03E8_0001, 32'h2710_4000, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hFFFF_FFFE, 32'h0000_0002};
		send_idle_pct = 0;
		stall_pct     = 0;
		foreach (values[i]) begin
			send_value(values[i]);
		end
		wait_for_drain();
	endtask

	// Random numbers in equal shares: full-range, short texts, small negatives
	// and integer parts on the decimal length boundaries.
	task automatic test_random(input int count, input int idle_pct, input int stall);
		logic [31:0] value;
		logic [15:0] bounds[10];
		bounds = '{16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000, 16'd9999,
			16'd10000, 16'd32767, 16'd65535};
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		repeat (count) begin
			case ($urandom_range(3))
				0: value = $urandom;
				1: value = {16'($urandom_range(9)), 16'($urandom)};
				2: value = {16'hFFFF, 16'($urandom)};
				default: value = {bounds[$urandom_range(9)], 16'($urandom)};
			endcase
			if ($urandom_range(1) == 1 && value[31] == 1'b0) begin
				value = 32'd0 - value;
			end
			send_value(value);
		end
	endtask

	// The sender stops mid-stream until all owed text has come out, then resumes.
	task automatic test_pause_and_resume();
		send_idle_pct = 0;
		stall_pct     = 30;
		repeat (3) begin
			repeat ($urandom_range(2, 5)) begin
				send_value($urandom);
			end
			wait_for_drain();
		end
	endtask

	// A long quiet spell means a hang.
	initial begin
		wait (quiet_cycles >= QuietLimit);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(50, 0, 0);
		test_random(50, 76, 0);
		test_random(50, 0, 76);
		test_random(50, 10, 10);
		test_pause_and_resume();

		wait_for_drain();
		repeat (TailCycles) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
